FILE: src/mmas_pkg.sv
// Package for the multi-method array search block: sizes, codes, request and
// result structs, sequencer states. No dependencies.
`default_nettype none

package mmas_pkg;

    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int ADDR_W      = 10;
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 12;

    // divide by three: x * 683 >> 11 is exact for x below 1024
    localparam int THIRD_MUL   = 683;
    localparam int THIRD_SHIFT = 11;
    localparam int PROD_W      = ADDR_W + THIRD_SHIFT;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] METHOD_LINEAR = 2'd0;
    localparam logic [1:0] METHOD_BINARY = 2'd1;
    localparam logic [1:0] METHOD_TERN   = 2'd2;
    localparam logic [1:0] METHOD_FIB    = 2'd3;

    typedef struct packed {
        logic [1:0]             kind;
        logic [VALUE_WIDTH-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_index;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_END,
        S_FIB_INIT,
        S_SEARCH,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_TER2_RD,
        S_TER2_CMP,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: src/multi_method_array_search.sv
// Multi-method array search: element store, in-place bubble sort and a
// probe sequencer around one shared comparator. Depends on mmas_pkg.
//
//  channel | direction | handshake          | payload
//  in      | request   | i_in_valid/o_in_stall   | mmas_pkg::t_in_item
//  out     | result    | o_out_valid/i_out_stall | mmas_pkg::t_out_item
//  cfg     | write     | i_cfg_valid/o_cfg_ready | search method, 2 bits
//
// Append and clear requests complete in the idle state. A search reads the store
// through one registered read port; a ternary step makes two probes.
// Fibonacci search first builds its Fibonacci numbers in a setup state.
// The first sorted search after appends runs bubble passes, up to n passes.
// Reset empties the store; a result waits in the output register under stall
// while the next request is taken.
`default_nettype none

module multi_method_array_search (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire mmas_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output mmas_pkg::t_out_item       o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_data
);
    import mmas_pkg::*;

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    t_state r_state, n_state;
    logic [1:0]             r_method;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_sorted, n_sorted;
    logic [VALUE_WIDTH-1:0] r_key, n_key;
    logic [CNT_W-1:0]       r_k, n_k;
    logic                   r_swapped, n_swapped;
    logic [VALUE_WIDTH-1:0] r_carry, n_carry;
    logic signed [IDX_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic signed [IDX_W-1:0] r_m1, n_m1, r_m2, n_m2;
    logic                   r_gt1, n_gt1;
    logic [IDX_W-1:0]       r_f, n_f, r_f1, n_f1, r_f2, n_f2;
    logic signed [IDX_W-1:0] r_base, n_base;
    logic                   r_fib_last, n_fib_last;
    logic [ADDR_W-1:0]      r_rd_addr, n_rd_addr;
    logic                   r_res_found, n_res_found;
    logic [ADDR_W-1:0]      r_res_idx, n_res_idx;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    logic                   in_acc, out_free;
    logic [VALUE_WIDTH-1:0] cmp_b;
    logic                   cmp_lt, cmp_eq;
    logic signed [IDX_W-1:0] cnt_s, last_s, probe_s, mid, diff, third, m1, m2;
    logic signed [IDX_W-1:0] fib_raw, fib_idx;
    logic [PROD_W-1:0]      third_prod;
    logic                   search_end, fib_tail;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // shared comparator: stored value against key, or against the carry while sorting
    assign cmp_b  = (r_state == S_SORT_CMP) ? r_carry : r_key;
    assign cmp_lt = r_rdata < cmp_b;
    assign cmp_eq = r_rdata == cmp_b;

    assign cnt_s      = $signed({1'b0, r_count});
    assign last_s     = cnt_s - 12'sd1;
    assign probe_s    = $signed({2'b00, r_rd_addr});
    assign mid        = r_lo + ((r_hi - r_lo) >>> 1);
    assign diff       = r_hi - r_lo;
    assign third_prod = PROD_W'(diff[ADDR_W-1:0]) * PROD_W'(THIRD_MUL);
    assign third      = $signed({2'b00, third_prod[PROD_W-1:THIRD_SHIFT]});
    assign m1         = r_lo + third;
    assign m2         = r_hi - third;
    assign fib_raw    = r_base + $signed(r_f2);
    assign fib_idx    = (fib_raw > last_s) ? last_s :
                        (fib_raw < 12'sd0) ? 12'sd0 : fib_raw;
    assign fib_tail   = (r_f1 != '0) && ((r_base + 12'sd1) < cnt_s);

    always_comb begin
        case (r_method)
            METHOD_LINEAR: search_end = (r_k == r_count);
            METHOD_BINARY: search_end = (r_lo > r_hi);
            METHOD_TERN:   search_end = (r_hi < r_lo);
            default:       search_end = (r_f <= IDX_W'(1)) && !fib_tail;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_item.kind == KIND_SEARCH) begin
                    if (r_count == '0)
                        n_state = S_OUT;
                    else if (r_method != METHOD_LINEAR && !r_sorted)
                        n_state = S_SORT_RD;
                    else if (r_method == METHOD_FIB)
                        n_state = S_FIB_INIT;
                    else
                        n_state = S_SEARCH;
                end
            end
            S_SORT_RD:  n_state = S_SORT_CMP;
            S_SORT_CMP: n_state = (r_k + CNT_W'(1) == r_count) ? S_SORT_END : S_SORT_RD;
            S_SORT_END: begin
                if (r_swapped)
                    n_state = S_SORT_RD;
                else if (r_method == METHOD_FIB)
                    n_state = S_FIB_INIT;
                else
                    n_state = S_SEARCH;
            end
            S_FIB_INIT: if (r_f >= {1'b0, r_count}) n_state = S_SEARCH;
            S_SEARCH:   n_state = search_end ? S_OUT : S_PROBE_RD;
            S_PROBE_RD: n_state = S_PROBE_CMP;
            S_PROBE_CMP: begin
                if (cmp_eq || (r_method == METHOD_FIB && r_fib_last))
                    n_state = S_OUT;
                else if (r_method == METHOD_TERN)
                    n_state = S_TER2_RD;
                else
                    n_state = S_SEARCH;
            end
            S_TER2_RD:  n_state = S_TER2_CMP;
            S_TER2_CMP: n_state = cmp_eq ? S_OUT : S_SEARCH;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and store write
    always_comb begin
        n_count = r_count;      n_sorted = r_sorted;   n_key = r_key;
        n_k = r_k;              n_swapped = r_swapped; n_carry = r_carry;
        n_lo = r_lo;            n_hi = r_hi;           n_m1 = r_m1;
        n_m2 = r_m2;            n_gt1 = r_gt1;         n_f = r_f;
        n_f1 = r_f1;            n_f2 = r_f2;           n_base = r_base;
        n_fib_last = r_fib_last; n_rd_addr = r_rd_addr;
        n_res_found = r_res_found; n_res_idx = r_res_idx;
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = r_carry;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.kind)
                        KIND_APPEND: begin
                            if (r_count != CNT_W'(DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[ADDR_W-1:0];
                                mem_wdata = i_in_item.item_value;
                                n_count   = r_count + CNT_W'(1);
                                n_sorted  = 1'b0;
                            end
                        end
                        KIND_SEARCH: begin
                            n_key = i_in_item.item_value;
                            n_k = '0;  n_swapped = 1'b0;  n_rd_addr = '0;
                            n_lo = '0; n_hi = last_s;
                            n_f2 = '0; n_f1 = IDX_W'(1); n_f = IDX_W'(1);
                            n_base = '1; n_fib_last = 1'b0;
                            n_res_found = 1'b0; n_res_idx = '0;
                        end
                        KIND_CLEAR: begin
                            n_count  = '0;
                            n_sorted = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT_CMP: begin
                // carry the larger value up the pass, drop the smaller one behind
                if (r_k == '0) begin
                    n_carry = r_rdata;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_k - CNT_W'(1));
                    if (cmp_lt) begin
                        mem_wdata = r_rdata;
                        n_swapped = 1'b1;
                    end else begin
                        mem_wdata = r_carry;
                        n_carry   = r_rdata;
                    end
                end
                n_k       = r_k + CNT_W'(1);
                n_rd_addr = ADDR_W'(r_k + CNT_W'(1));
            end
            S_SORT_END: begin
                mem_we    = 1'b1;
                mem_waddr = last_s[ADDR_W-1:0];
                mem_wdata = r_carry;
                n_k = '0; n_swapped = 1'b0; n_rd_addr = '0;
                if (!r_swapped) n_sorted = 1'b1;
            end
            S_FIB_INIT: begin
                if (r_f < {1'b0, r_count}) begin
                    n_f2 = r_f1;
                    n_f1 = r_f;
                    n_f  = r_f + r_f1;
                end
            end
            S_SEARCH: begin
                case (r_method)
                    METHOD_LINEAR: n_rd_addr = r_k[ADDR_W-1:0];
                    METHOD_BINARY: n_rd_addr = mid[ADDR_W-1:0];
                    METHOD_TERN: begin
                        n_rd_addr = m1[ADDR_W-1:0];
                        n_m1 = m1;
                        n_m2 = m2;
                    end
                    default: begin
                        if (r_f > IDX_W'(1)) begin
                            n_rd_addr = fib_idx[ADDR_W-1:0];
                        end else begin
                            n_rd_addr  = ADDR_W'(r_base + 12'sd1);
                            n_fib_last = 1'b1;
                        end
                    end
                endcase
            end
            S_PROBE_CMP: begin
                if (cmp_eq) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_rd_addr;
                end else begin
                    case (r_method)
                        METHOD_LINEAR: n_k = r_k + CNT_W'(1);
                        METHOD_BINARY: begin
                            if (cmp_lt) n_lo = probe_s + 12'sd1;
                            else        n_hi = probe_s - 12'sd1;
                        end
                        METHOD_TERN: begin
                            n_gt1     = !cmp_lt;
                            n_rd_addr = r_m2[ADDR_W-1:0];
                        end
                        default: begin
                            if (cmp_lt) begin
                                n_f    = r_f1;
                                n_f1   = r_f2;
                                n_f2   = r_f1 - r_f2;
                                n_base = probe_s;
                            end else begin
                                n_f    = r_f2;
                                n_f1   = r_f1 - r_f2;
                                n_f2   = r_f2 - (r_f1 - r_f2);
                            end
                        end
                    endcase
                end
            end
            S_TER2_CMP: begin
                if (cmp_eq) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_rd_addr;
                end else if (r_gt1) begin
                    n_hi = r_m1 - 12'sd1;
                end else if (cmp_lt) begin
                    n_lo = r_m2 + 12'sd1;
                end else begin
                    n_lo = r_m1 + 12'sd1;
                    n_hi = r_m2 - 12'sd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_method    <= METHOD_LINEAR;
            r_count     <= '0;
            r_sorted    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sorted <= n_sorted;
            if (i_cfg_valid && o_cfg_ready) r_method <= i_cfg_data;
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;  r_k <= n_k;  r_swapped <= n_swapped;  r_carry <= n_carry;
        r_lo <= n_lo;  r_hi <= n_hi;  r_m1 <= n_m1;  r_m2 <= n_m2;  r_gt1 <= n_gt1;
        r_f <= n_f;  r_f1 <= n_f1;  r_f2 <= n_f2;  r_base <= n_base;
        r_fib_last <= n_fib_last;  r_rd_addr <= n_rd_addr;
        r_res_found <= n_res_found;  r_res_idx <= n_res_idx;
        if (r_state == S_OUT && out_free) begin
            r_out.found       <= r_res_found;
            r_out.match_index <= r_res_idx;
        end
    end

endmodule

`default_nettype wire

FILE: src/mmas_checker.sv
// Port checker for multi_method_array_search, attached by bind.
// Depends on mmas_pkg.
`default_nettype none

module mmas_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire mmas_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire mmas_pkg::t_out_item o_out_item
);
    import mmas_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.kind == KIND_SEARCH) |=> o_in_stall)
        else $error("search request did not occupy the sequencer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.match_index == '0))
        else $error("miss with non-zero index");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs not cleared by reset");

endmodule

bind multi_method_array_search mmas_checker u_mmas_checker (.*);

`default_nettype wire

FILE: tb/sv/multi_method_array_search_test.sv
// Self-checking testbench for multi_method_array_search: directed table, per-method
// and full-store runs, then random append/search/clear traffic checked against a
// local search model. Depends on mmas_pkg and the multi_method_array_search RTL.
`default_nettype none

module multi_method_array_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mmas_pkg::*;

    localparam int MAX_CYCLES = 20000000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = '0;

    multi_method_array_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // search model state
    logic [VALUE_WIDTH-1:0] model_store [DEPTH];
    int unsigned            model_count = 0;
    bit                     model_sorted = 1'b1;
    logic [1:0]             model_method = METHOD_LINEAR;

    t_out_item   pending_results [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          calm_phase = 1'b0;
    bit          hold_off_req = 1'b0;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_row;

    function automatic void sort_model();
        bit swapped;
        logic [VALUE_WIDTH-1:0] t;
        swapped = 1'b1;
        while (swapped) begin
            swapped = 1'b0;
            for (int k = 1; k < model_count; k++) begin
                if (model_store[k] < model_store[k-1]) begin
                    t = model_store[k];
                    model_store[k] = model_store[k-1];
                    model_store[k-1] = t;
                    swapped = 1'b1;
                end
            end
        end
    endfunction

    function automatic int search_linear(logic [VALUE_WIDTH-1:0] key);
        for (int k = 0; k < model_count; k++)
            if (model_store[k] == key) return k;
        return -1;
    endfunction

    function automatic int search_binary(logic [VALUE_WIDTH-1:0] key);
        int lo, hi, mid;
        lo = 0;
        hi = int'(model_count) - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (model_store[mid] == key) return mid;
            if (model_store[mid] < key) lo = mid + 1;
            else hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic int search_ternary(logic [VALUE_WIDTH-1:0] key);
        int lo, hi, third, m1, m2;
        lo = 0;
        hi = int'(model_count) - 1;
        while (hi >= lo) begin
            third = (hi - lo) / 3;
            m1 = lo + third;
            m2 = hi - third;
            if (model_store[m1] == key) return m1;
            if (model_store[m2] == key) return m2;
            if (key < model_store[m1]) hi = m1 - 1;
            else if (key > model_store[m2]) lo = m2 + 1;
            else begin
                lo = m1 + 1;
                hi = m2 - 1;
            end
        end
        return -1;
    endfunction

    function automatic int search_fibonacci(logic [VALUE_WIDTH-1:0] key);
        int n, f2, f1, f, base, i;
        n = int'(model_count);
        f2 = 0;
        f1 = 1;
        f = 1;
        base = -1;
        while (f < n) begin
            f2 = f1;
            f1 = f;
            f = f1 + f2;
        end
        while (f > 1) begin
            i = base + f2;
            if (i > n - 1) i = n - 1;
            if (i < 0) i = 0;
            if (model_store[i] < key) begin
                f = f1;
                f1 = f2;
                f2 = f - f1;
                base = i;
            end else if (model_store[i] > key) begin
                f = f2;
                f1 = f1 - f2;
                f2 = f - f1;
            end else begin
                return i;
            end
        end
        // last probe only when it lies inside the store
        if (f1 != 0 && base + 1 >= 0 && base + 1 < n && model_store[base+1] == key)
            return base + 1;
        return -1;
    endfunction

    // advance the model by one request; returns 1 when a result is due
    function automatic bit apply_request(t_in_item req, output t_out_item res);
        int r;
        res = '0;
        case (req.kind)
            KIND_APPEND: begin
                if (model_count < DEPTH) begin
                    model_store[model_count] = req.item_value;
                    model_count++;
                    model_sorted = 1'b0;
                end
                return 1'b0;
            end
            KIND_CLEAR: begin
                model_count = 0;
                model_sorted = 1'b1;
                return 1'b0;
            end
            KIND_SEARCH: begin
                r = -1;
                if (model_count != 0) begin
                    if (model_method != METHOD_LINEAR && !model_sorted) begin
                        sort_model();
                        model_sorted = 1'b1;
                    end
                    case (model_method)
                        METHOD_BINARY: r = search_binary(req.item_value);
                        METHOD_TERN:   r = search_ternary(req.item_value);
                        METHOD_FIB:    r = search_fibonacci(req.item_value);
                        default:       r = search_linear(req.item_value);
                    endcase
                end
                if (r >= 0) begin
                    res.found = 1'b1;
                    res.match_index = r[ADDR_W-1:0];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit idle_roll();
        return !calm_phase && ($urandom_range(99) < 17);
    endfunction

    // valid stays high from one request to the next unless the sender idles
    task automatic send_request(t_in_item req);
        if (idle_roll()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_roll());
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic issue(t_in_item req);
        t_out_item res;
        if (apply_request(req, res)) pending_results.push_back(res);
        send_request(req);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_method(logic [1:0] m);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_method = m;
    endtask

    function automatic t_in_item mk(logic [1:0] k, logic [VALUE_WIDTH-1:0] v);
        t_in_item r;
        r.kind = k;
        r.item_value = v;
        return r;
    endfunction

    // result side: stall at random or while hold_off_req is set, check against oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_item);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.found !== want.found) begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, o_out_item.found);
                        error_count++;
                    end
                    if (o_out_item.match_index !== want.match_index) begin
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.match_index, o_out_item.match_index);
                        error_count++;
                    end
                end
            end
            i_out_stall <= hold_off_req || idle_roll();
        end
        if (cycle_count > MAX_CYCLES) begin
            $display("FAIL multi_method_array_search");
            $finish;
        end
    end

    t_row directed [$];

    initial begin
        t_row row;
        t_out_item res;
        int kind_roll;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: expected typed in where obvious, else from model
        directed.push_back('{mk(KIND_SEARCH, 16'h0000), 1'b1, '{1'b0, '0}});
        directed.push_back('{mk(KIND_UNUSED, 16'hFFFF), 1'b0, '0});
        directed.push_back('{mk(KIND_APPEND, 16'hFFFF), 1'b0, '0});
        directed.push_back('{mk(KIND_APPEND, 16'h0000), 1'b0, '0});
        directed.push_back('{mk(KIND_APPEND, 16'h8000), 1'b0, '0});
        directed.push_back('{mk(KIND_APPEND, 16'h0000), 1'b0, '0});
        directed.push_back('{mk(KIND_SEARCH, 16'hFFFF), 1'b1, '{1'b1, 10'd0}});
        directed.push_back('{mk(KIND_SEARCH, 16'h0000), 1'b1, '{1'b1, 10'd1}});
        directed.push_back('{mk(KIND_SEARCH, 16'h1234), 1'b1, '{1'b0, '0}});
        directed.push_back('{mk(KIND_SEARCH, 16'h8000), 1'b0, '0});
        directed.push_back('{mk(KIND_CLEAR, 16'h5555), 1'b0, '0});
        directed.push_back('{mk(KIND_SEARCH, 16'hFFFF), 1'b1, '{1'b0, '0}});
        directed.push_back('{mk(KIND_APPEND, 16'hAAAA), 1'b0, '0});
        directed.push_back('{mk(KIND_SEARCH, 16'hAAAA), 1'b1, '{1'b1, 10'd0}});
        foreach (directed[i]) begin
            row = directed[i];
            void'(apply_request(row.req, res));
            if (row.typed) res = row.want;
            if (row.req.kind == KIND_SEARCH) pending_results.push_back(res);
            send_request(row.req);
        end

        // each sorting method on a small unsorted store, plus fill to full
        for (int m = 1; m < 4; m++) begin
            write_method(2'(m));
            issue(mk(KIND_CLEAR, 16'h0));
            for (int k = 0; k < 7; k++) issue(mk(KIND_APPEND, 16'(100 - 13 * k)));
            issue(mk(KIND_SEARCH, 16'd100));
            issue(mk(KIND_SEARCH, 16'd22));
            issue(mk(KIND_SEARCH, 16'd50));
        end
        write_method(METHOD_LINEAR);
        issue(mk(KIND_CLEAR, 16'h0));
        calm_phase = 1'b1;
        for (int k = 0; k < DEPTH + 2; k++) issue(mk(KIND_APPEND, 16'($urandom)));
        issue(mk(KIND_SEARCH, model_store[DEPTH-1]));
        issue(mk(KIND_SEARCH, model_store[DEPTH/2]));
        write_method(METHOD_FIB);
        issue(mk(KIND_SEARCH, model_store[DEPTH-1]));
        issue(mk(KIND_SEARCH, model_store[0]));
        issue(mk(KIND_CLEAR, 16'h0));
        calm_phase = 1'b0;

        // random phases: small stores, mostly searches for stored keys
        for (int phase = 0; phase < 12; phase++) begin
            write_method(phase < 4 ? 2'(phase) : 2'($urandom));
            calm_phase = (phase == 6);
            if (phase == 3) begin
                fork
                    begin
                        hold_off_req = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off_req = 1'b0;
                    end
                join_none
            end
            for (int j = 0; j < 48; j++) begin
                kind_roll = $urandom_range(99);
                if (kind_roll < 40 && model_count < 40)
                    issue(mk(KIND_APPEND, $urandom_range(3) == 0 ?
                             16'($urandom) : 16'($urandom_range(40))));
                else if (kind_roll < 92) begin
                    if (model_count != 0 && $urandom_range(2) != 0)
                        issue(mk(KIND_SEARCH,
                                 model_store[$urandom_range(model_count - 1)]));
                    else
                        issue(mk(KIND_SEARCH, 16'($urandom)));
                end else if (kind_roll < 96)
                    issue(mk(KIND_CLEAR, 16'($urandom)));
                else
                    issue(mk(KIND_UNUSED, 16'($urandom)));
            end
        end
        calm_phase = 1'b0;
        drain_results();

        if (error_count == 0)
            $display("PASS multi_method_array_search");
        else
            $display("FAIL multi_method_array_search");
        $finish;
    end

endmodule

`default_nettype wire
